// ===== sv/wd128_pkg.sv =====
// shared types and constants for the 128-by-64 restoring divider
// no dependencies

package wd128_pkg;

   localparam int FIELD_BITS     = 64;
   localparam int WORD_BITS_DFLT = 64;

   // control flags that travel with a request through the cell chain
   typedef struct packed {
      logic valid;
      logic overflow;
      logic div_zero;
   } wd128_flags_type;

endpackage

// ===== sv/wd128_cell.sv =====
// one restoring-division cell: produces one quotient bit per request per cycle
// depends on wd128_pkg

module wd128_cell
   import wd128_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DFLT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  wd128_flags_type      flags_i,
   input  logic [WORD_BITS-1:0] rem_i,
   input  logic [WORD_BITS-1:0] lq_i,
   input  logic [WORD_BITS-1:0] dv_i,
   output wd128_flags_type      flags_o,
   output logic [WORD_BITS-1:0] rem_o,
   output logic [WORD_BITS-1:0] lq_o,
   output logic [WORD_BITS-1:0] dv_o
);

   wd128_flags_type      flags_ff;
   logic [WORD_BITS-1:0] rem_ff, rem_in;
   logic [WORD_BITS-1:0] lq_ff, lq_in;
   logic [WORD_BITS-1:0] dv_ff;
   logic [WORD_BITS-1:0] shifted;
   logic [WORD_BITS:0]   diff;
   logic                 take;

   // partial remainder is {carry, shifted}; it stays below twice the divisor
   always_comb begin
      shifted = {rem_i[WORD_BITS-2:0], lq_i[WORD_BITS-1]};
      diff    = {rem_i[WORD_BITS-1], shifted} - {1'b0, dv_i};
      take    = ~diff[WORD_BITS];
      rem_in  = take ? diff[WORD_BITS-1:0] : shifted;
      // dividend bits leave at the top, quotient bits enter at the bottom
      lq_in   = {lq_i[WORD_BITS-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_i;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      lq_ff  <= lq_in;
      dv_ff  <= dv_i;
   end

   assign flags_o = flags_ff;
   assign rem_o   = rem_ff;
   assign lq_o    = lq_ff;
   assign dv_o    = dv_ff;

endmodule

// ===== sv/wide_divider_128_by_64_top.sv =====
// top level of the 128-by-64 unsigned divider: entry stage, cell chain, result stage
// depends on wd128_pkg and wd128_cell
//
// a request passes the entry, cell and result registers on its way to rsp_valid
// throughput: one request per cycle; busy stays low, and the entry stage, the
//    WORD_BITS subtract cells and result stage hold WORD_BITS + 2 requests in flight
// reset clears the valid flags of every stage; requests in flight are dropped
// results cannot be stalled by the receiver

module wide_divider_128_by_64_top
   import wd128_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DFLT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [FIELD_BITS-1:0] req_dividend_low,
   input  logic [FIELD_BITS-1:0] req_dividend_high,
   input  logic [FIELD_BITS-1:0] req_divisor,
   output logic                  rsp_valid,
   output logic [FIELD_BITS-1:0] rsp_quotient,
   output logic [FIELD_BITS-1:0] rsp_remainder,
   output logic                  rsp_overflow,
   output logic                  rsp_divide_by_zero
);

   localparam int LATENCY = WORD_BITS + 2;

   logic [WORD_BITS-1:0] lo_w, hi_w, dv_w;
   logic                 ovf_w;
   wd128_flags_type      flags_in;
   logic [WORD_BITS-1:0] rem0_in, lq0_in;

   wd128_flags_type      chain_flags [WORD_BITS+1];
   logic [WORD_BITS-1:0] chain_rem   [WORD_BITS+1];
   logic [WORD_BITS-1:0] chain_lq    [WORD_BITS+1];
   logic [WORD_BITS-1:0] chain_dv    [WORD_BITS+1];

   wd128_flags_type      head_flags_ff;
   logic [WORD_BITS-1:0] head_rem_ff, head_lq_ff, head_dv_ff;

   wd128_flags_type      out_flags_ff;
   logic [WORD_BITS-1:0] out_quo_ff, out_quo_in;
   logic [WORD_BITS-1:0] out_rem_ff;

   assign busy = 1'b0;

   // entry stage: an oversize quotient divides (0 : high) instead, which leaves
   // high mod divisor as remainder; a zero divisor then passes high straight through
   always_comb begin
      lo_w              = req_dividend_low[WORD_BITS-1:0];
      hi_w              = req_dividend_high[WORD_BITS-1:0];
      dv_w              = req_divisor[WORD_BITS-1:0];
      ovf_w             = (hi_w >= dv_w);
      flags_in.valid    = start & ~busy;
      flags_in.overflow = ovf_w;
      flags_in.div_zero = (dv_w == '0);
      rem0_in           = ovf_w ? '0 : hi_w;
      lq0_in            = ovf_w ? hi_w : lo_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_flags_ff <= '0;
      end else begin
         head_flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      head_rem_ff <= rem0_in;
      head_lq_ff  <= lq0_in;
      head_dv_ff  <= dv_w;
   end

   assign chain_flags[0] = head_flags_ff;
   assign chain_rem[0]   = head_rem_ff;
   assign chain_lq[0]    = head_lq_ff;
   assign chain_dv[0]    = head_dv_ff;

   for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
      wd128_cell #(
         .WORD_BITS (WORD_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .flags_i (chain_flags[i]),
         .rem_i   (chain_rem[i]),
         .lq_i    (chain_lq[i]),
         .dv_i    (chain_dv[i]),
         .flags_o (chain_flags[i+1]),
         .rem_o   (chain_rem[i+1]),
         .lq_o    (chain_lq[i+1]),
         .dv_o    (chain_dv[i+1])
      );
   end

   assign out_quo_in = chain_flags[WORD_BITS].overflow ? '1 : chain_lq[WORD_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_flags_ff <= '0;
      end else begin
         out_flags_ff <= chain_flags[WORD_BITS];
      end
   end

   always_ff @(posedge clock) begin
      out_quo_ff <= out_quo_in;
      out_rem_ff <= chain_rem[WORD_BITS];
   end

   assign rsp_valid          = out_flags_ff.valid;
   assign rsp_overflow       = out_flags_ff.overflow;
   assign rsp_divide_by_zero = out_flags_ff.div_zero;
   assign rsp_quotient       = FIELD_BITS'(out_quo_ff);
   assign rsp_remainder      = FIELD_BITS'(out_rem_ff);

   // every request comes out after the fixed pipeline depth
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("request did not complete after pipeline latency");

   a_dbz_implies_ovf : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |-> rsp_overflow)
      else $error("zero divisor without overflow flag");

   a_ovf_quotient : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |-> (out_quo_ff == '1))
      else $error("overflow result without saturated quotient");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(chain_flags[WORD_BITS].valid))
      else $error("result strobe without a request leaving the chain");

endmodule
